>>> sv/i2cm_pkg.sv
package i2cm_pkg;

    // Item kinds on the command/tick channel.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [15:0] HALF_BIT_RESET = 16'd10;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_WBIT  = 3'd2,
        PH_WACK  = 3'd3,
        PH_RBIT  = 3'd4,
        PH_RNACK = 3'd5,
        PH_STOP  = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  quarter;
        logic [15:0] div_count;
        logic [2:0]  bit_count;
        logic [1:0]  byte_index;
        logic [7:0]  shift_byte;
        logic [7:0]  saved0;
        logic [7:0]  saved1;
        logic [7:0]  saved2;
        logic        is_read;
        logic        nack_flag;
        logic [7:0]  received;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:      PH_IDLE,
        quarter:    2'd0,
        div_count:  16'd0,
        bit_count:  3'd0,
        byte_index: 2'd0,
        shift_byte: 8'd0,
        saved0:     8'd0,
        saved1:     8'd0,
        saved2:     8'd0,
        is_read:    1'b0,
        nack_flag:  1'b0,
        received:   8'd0
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] dev_address;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       nack;
        logic [7:0] read_data;
    } t_result;

endpackage

>>> sv/i2cm_step.sv
module i2cm_step (
    input  i2cm_pkg::t_state  i_state,
    input  i2cm_pkg::t_item   i_item,
    input  logic [15:0]       i_half_bit,
    output i2cm_pkg::t_state  o_state,
    output i2cm_pkg::t_result o_result
);
    import i2cm_pkg::*;

    logic [15:0] half_len;
    logic [15:0] lo_len;
    logic [15:0] hi_len;
    logic [15:0] seg_len;
    logic [1:0]  last_quarter;
    logic [16:0] count_inc;
    logic [3:0]  bit_inc;
    logic [1:0]  byte_inc;
    logic        done;
    logic        cur_bit;
    logic        prev_bit;
    t_state      n;

    assign half_len = (i_half_bit == 16'd0) ? 16'd1 : i_half_bit;
    assign lo_len   = half_len >> 1;
    assign hi_len   = half_len - lo_len;
    assign count_inc = {1'b0, i_state.div_count} + 17'd1;
    assign bit_inc   = {1'b0, i_state.bit_count} + 4'd1;
    assign byte_inc  = i_state.byte_index + 2'd1;

    // The data bit segment is split around the SDA change point.
    always_comb begin
        if (i_state.phase == PH_WBIT && i_state.quarter == 2'd0) begin
            seg_len = (lo_len == 16'd0) ? 16'd1 : lo_len;
        end else if (i_state.phase == PH_WBIT && i_state.quarter == 2'd1) begin
            seg_len = hi_len;
        end else begin
            seg_len = half_len;
        end
        last_quarter = (i_state.phase == PH_WBIT || i_state.phase == PH_STOP) ? 2'd2 : 2'd1;
    end

    always_comb begin
        n    = i_state;
        done = 1'b0;
        if ((i_item.kind == KIND_WRITE || i_item.kind == KIND_READ) &&
            i_state.phase == PH_IDLE) begin
            n.saved0     = i_item.dev_address;
            n.saved1     = i_item.reg_address;
            n.saved2     = i_item.write_data;
            n.is_read    = i_item.kind[0];
            n.nack_flag  = 1'b0;
            if (i_item.kind[0]) begin
                n.received = 8'd0;
            end
            n.bit_count  = 3'd0;
            n.byte_index = 2'd0;
            n.shift_byte = 8'd0;
            n.phase      = PH_START;
            n.quarter    = 2'd0;
            n.div_count  = 16'd0;
        end else if (i_item.kind == KIND_TICK && i_state.phase != PH_IDLE) begin
            if (count_inc >= {1'b0, seg_len}) begin
                n.div_count = 16'd0;
                if (i_state.quarter != last_quarter) begin
                    n.quarter = i_state.quarter + 2'd1;
                end else begin
                    n.quarter = 2'd0;
                    case (i_state.phase)
                        PH_START: begin
                            n.byte_index = 2'd0;
                            n.bit_count  = 3'd0;
                            n.shift_byte = i_state.saved0;
                            n.phase      = PH_WBIT;
                        end
                        PH_WBIT: begin
                            n.bit_count = bit_inc[2:0];
                            n.phase     = bit_inc[3] ? PH_WACK : PH_WBIT;
                        end
                        PH_WACK: begin
                            if (i_item.sda_in) begin
                                n.nack_flag = 1'b1;
                                n.phase     = PH_STOP;
                            end else begin
                                n.byte_index = byte_inc;
                                if (i_state.is_read && byte_inc >= 2'd2) begin
                                    n.bit_count  = 3'd0;
                                    n.shift_byte = 8'd0;
                                    n.phase      = PH_RBIT;
                                end else if (!i_state.is_read && byte_inc == 2'd3) begin
                                    n.phase = PH_STOP;
                                end else begin
                                    n.bit_count  = 3'd0;
                                    n.shift_byte = (byte_inc == 2'd1) ? i_state.saved1
                                                                      : i_state.saved2;
                                    n.phase      = PH_WBIT;
                                end
                            end
                        end
                        PH_RBIT: begin
                            n.shift_byte = {i_state.shift_byte[6:0], i_item.sda_in};
                            n.bit_count  = bit_inc[2:0];
                            if (bit_inc[3]) begin
                                n.received = {i_state.shift_byte[6:0], i_item.sda_in};
                                n.phase    = PH_RNACK;
                            end else begin
                                n.phase = PH_RBIT;
                            end
                        end
                        PH_RNACK: begin
                            n.phase = PH_STOP;
                        end
                        PH_STOP: begin
                            n.phase      = PH_IDLE;
                            n.bit_count  = 3'd0;
                            n.byte_index = 2'd0;
                            done         = 1'b1;
                        end
                        default: begin
                            n.phase = PH_IDLE;
                        end
                    endcase
                end
            end else begin
                n.div_count = count_inc[15:0];
            end
        end
    end

    // Bit on SDA for the current and the previous data bit of the byte.
    assign cur_bit = n.shift_byte[3'd7 - n.bit_count];
    always_comb begin
        if (n.bit_count == 3'd0) begin
            prev_bit = (n.byte_index != 2'd0);
        end else begin
            prev_bit = n.shift_byte[3'd0 - n.bit_count];
        end
    end

    always_comb begin
        o_result.busy_res  = (n.phase != PH_IDLE);
        o_result.done_res  = done;
        o_result.nack      = n.nack_flag;
        o_result.read_data = n.received;
        case (n.phase)
            PH_START: begin
                o_result.scl_level = 1'b1;
                o_result.sda_level = (n.quarter == 2'd0);
            end
            PH_WBIT: begin
                o_result.scl_level = (n.quarter == 2'd2);
                o_result.sda_level = (n.quarter == 2'd0) ? prev_bit : cur_bit;
            end
            PH_WACK, PH_RBIT, PH_RNACK: begin
                o_result.scl_level = (n.quarter == 2'd1);
                o_result.sda_level = 1'b1;
            end
            PH_STOP: begin
                o_result.scl_level = (n.quarter != 2'd0);
                o_result.sda_level = (n.quarter == 2'd2);
            end
            default: begin
                o_result.scl_level = 1'b1;
                o_result.sda_level = 1'b1;
            end
        endcase
    end

    assign o_state = n;

endmodule

>>> sv/i2c_register_access_master.sv
// I2C register access master. Each input transaction is either a command (register
// write: device, register and data bytes; register read: device and register bytes,
// then one byte read back and answered with a master NACK) or a tick, which carries
// the sampled SDA level and advances the bit timing by one count. half_bit_ticks sets
// the half SCL period in ticks (zero acts as one); the user must write it through the
// configuration channel only while the block is idle, as the block does not enforce it.
// Every input transaction produces exactly one result transaction carrying the pin
// levels, busy, a done pulse on the tick where STOP completes, the nack flag and the
// last read byte. Commands that arrive while busy, ticks while idle and the unused kind
// code leave the state alone. One transaction is accepted per clock unless the
// result register is full and stalled. Each input is held in the input register,
// passes the single next-state stage and is offered from the result register.
// Clock stretching and repeated START are not supported.
module i2c_register_access_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command and tick channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_dev_address,
    input  logic [7:0]  i_reg_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_sda_in,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_nack,
    output logic [7:0]  o_read_data,
    // Configuration channel: half_bit_ticks.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import i2cm_pkg::*;

    logic        r_in_valid;
    t_item       r_item;
    logic        r_out_valid;
    t_result     r_result;
    t_state      r_state;
    logic [15:0] r_half_bit;

    t_state      n_state;
    t_result     n_result;
    logic        in_accept;
    logic        advance;

    // The input register moves forward whenever the result register is free or its
    // result is being taken in this cycle, so the input waits only while the result is stalled.
    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    i2cm_step u_step (
        .i_state    (r_state),
        .i_item     (r_item),
        .i_half_bit (r_half_bit),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    // Control state: handshake flags, protocol state and the divider setting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_half_bit  <= HALF_BIT_RESET;
        end else begin
            r_in_valid  <= in_accept || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_half_bit <= i_cfg_data;
            end
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.kind        <= i_kind;
            r_item.dev_address <= i_dev_address;
            r_item.reg_address <= i_reg_address;
            r_item.write_data  <= i_write_data;
            r_item.sda_in      <= i_sda_in;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_result.scl_level;
    assign o_sda_level = r_result.sda_level;
    assign o_busy_res  = r_result.busy_res;
    assign o_done_res  = r_result.done_res;
    assign o_nack      = r_result.nack;
    assign o_read_data = r_result.read_data;

endmodule
